FILE: hw/rtl/hv_pkg.sv
`default_nettype none
package hv_pkg;

    typedef enum logic [1:0] {
        ST_PLACED = 2'd0,
        ST_OOR    = 2'd1,
        ST_TFULL  = 2'd2,
        ST_VFULL  = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        CFG_ORIGIN_X = 3'd0,
        CFG_ORIGIN_Y = 3'd1,
        CFG_ORIGIN_Z = 3'd2,
        CFG_SIZE_X   = 3'd3,
        CFG_SIZE_Y   = 3'd4,
        CFG_SIZE_Z   = 3'd5,
        CFG_LIMITS   = 3'd6,
        CFG_CAP      = 3'd7
    } t_cfg_idx;

    localparam logic signed [19:0] ORIGIN_X_RST = -20'sd75200;
    localparam logic signed [19:0] ORIGIN_Y_RST = -20'sd75200;
    localparam logic signed [19:0] ORIGIN_Z_RST = -20'sd2000;
    localparam logic [15:0] SIZE_X_RST = 16'd160;
    localparam logic [15:0] SIZE_Y_RST = 16'd160;
    localparam logic [15:0] SIZE_Z_RST = 16'd4000;
    localparam logic [47:0] LIMITS_RST = 48'd8590135236;
    localparam logic [6:0]  CAP_RST    = 7'd32;

    // hash multipliers per axis
    localparam logic [15:0] HASH_MX = 16'h9E37;
    localparam logic [15:0] HASH_MY = 16'h85EB;
    localparam logic [15:0] HASH_MZ = 16'hC2B3;

    localparam int DIV_STEPS = 32;

    typedef struct packed {
        logic signed [19:0] origin_x;
        logic signed [19:0] origin_y;
        logic signed [19:0] origin_z;
        logic [15:0]        size_x;
        logic [15:0]        size_y;
        logic [15:0]        size_z;
        logic [47:0]        limits;
        logic [6:0]         cap;
    } t_cfg;

    typedef struct packed {
        logic ld_point;
        logic clr_start;
        logic clr_step;
        logic div_step;
        logic range_latch;
        logic hidx_latch;
        logic probe_rd;
        logic probe_next;
        logic set_full;
        logic alloc;
        logic hit_latch;
        logic cnt_rd;
        logic cnt_upd;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic action;
        logic clr_last;
        logic div_last;
        logic oor;
        logic used;
        logic hit;
        logic probe_last;
        logic total_full;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

FILE: hw/rtl/hv_ctrl.sv
`default_nettype none
module hv_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire hv_pkg::t_stat i_stat,
    output hv_pkg::t_cmd       o_cmd
);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_CLEAR = 10'b00_0000_0010,
        S_DIVAX = 10'b00_0000_0100,
        S_RANGE = 10'b00_0000_1000,
        S_HASH  = 10'b00_0001_0000,
        S_PRD   = 10'b00_0010_0000,
        S_PCHK  = 10'b00_0100_0000,
        S_CRD   = 10'b00_1000_0000,
        S_CCHK  = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    if (i_stat.action) begin
                        o_cmd.clr_start = 1'b1;
                        n_state = S_CLEAR;
                    end else begin
                        o_cmd.ld_point = 1'b1;
                        n_state = S_DIVAX;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_DIVAX: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_RANGE;
            end
            S_RANGE: begin
                o_cmd.range_latch = 1'b1;
                n_state = i_stat.oor ? S_OUT : S_HASH;
            end
            S_HASH: begin
                o_cmd.hidx_latch = 1'b1;
                n_state = S_PRD;
            end
            S_PRD: begin
                o_cmd.probe_rd = 1'b1;
                n_state = S_PCHK;
            end
            S_PCHK: begin
                if (!i_stat.used) begin
                    if (i_stat.total_full) o_cmd.set_full = 1'b1;
                    else o_cmd.alloc = 1'b1;
                    n_state = S_OUT;
                end else if (i_stat.hit) begin
                    o_cmd.hit_latch = 1'b1;
                    n_state = S_CRD;
                end else if (i_stat.probe_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state = S_OUT;
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_CRD: begin
                o_cmd.cnt_rd = 1'b1;
                n_state = S_CCHK;
            end
            S_CCHK: begin
                o_cmd.cnt_upd = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

FILE: hw/rtl/hv_dp.sv
`default_nettype none
module hv_dp #(
    parameter int VOX_CAPACITY = 16384,
    parameter int HASH_SLOTS   = 16384
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire hv_pkg::t_cfg  i_cfg,
    input  wire hv_pkg::t_cmd  i_cmd,
    output hv_pkg::t_stat      o_stat,
    input  wire logic          i_s_tuser,
    input  wire logic [79:0]   i_s_tdata,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [1:0]         o_m_tuser,
    output logic [143:0]       o_m_tdata
);

    // HASH_SLOTS is a power of two: the hash is reduced by masking
    localparam int HW  = $clog2(HASH_SLOTS);
    localparam int VW  = $clog2(VOX_CAPACITY);
    localparam int HMW = 1 + 48 + VW;
    localparam logic [HW-1:0] IDX_LAST  = HW'(HASH_SLOTS - 1);
    localparam logic [HW:0]   PROBE_END = (HW + 1)'(HASH_SLOTS);
    localparam logic [VW:0]   VOX_END   = (VW + 1)'(VOX_CAPACITY);

    // input latch
    logic [15:0]        r_int;

    // three shift-subtract divider lanes, one quotient bit per cycle
    logic [31:0] r_dvd [3];
    logic [16:0] r_rem [3];
    logic [16:0] r_dvs [3];
    logic [2:0]  r_neg;
    logic [4:0]  r_dcnt;
    logic [31:0] n_dvd [3];
    logic [16:0] n_rem [3];

    always_comb begin
        logic [17:0] t;
        for (int i = 0; i < 3; i++) begin
            t = {r_rem[i], r_dvd[i][31]};
            if (t >= {1'b0, r_dvs[i]}) begin
                n_rem[i] = 17'(t - {1'b0, r_dvs[i]});
                n_dvd[i] = {r_dvd[i][30:0], 1'b1};
            end else begin
                n_rem[i] = t[16:0];
                n_dvd[i] = {r_dvd[i][30:0], 1'b0};
            end
        end
    end

    // sign-extended forms
    logic signed [20:0] pt_x, pt_y, pt_z, og_x, og_y, og_z;
    assign pt_x = 21'(signed'(i_s_tdata[19:0]));
    assign pt_y = 21'(signed'(i_s_tdata[39:20]));
    assign pt_z = 21'(signed'(i_s_tdata[59:40]));
    assign og_x = 21'(i_cfg.origin_x);
    assign og_y = 21'(i_cfg.origin_y);
    assign og_z = 21'(i_cfg.origin_z);

    logic signed [20:0] d_ax [3];
    assign d_ax[0] = pt_x - og_x;
    assign d_ax[1] = pt_y - og_y;
    assign d_ax[2] = pt_z - og_z;

    logic [15:0] sizes  [3];
    logic [15:0] counts [3];
    assign sizes[0]  = i_cfg.size_x;
    assign sizes[1]  = i_cfg.size_y;
    assign sizes[2]  = i_cfg.size_z;
    assign counts[0] = i_cfg.limits[15:0];
    assign counts[1] = i_cfg.limits[31:16];
    assign counts[2] = i_cfg.limits[47:32];

    logic [2:0] ax_bad;
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ax_bad[i] = r_neg[i] || (sizes[i] == 16'd0) || (r_dvd[i][31:16] != 16'd0)
                        || (r_dvd[i][15:0] >= counts[i]);
        end
    end

    // result fields
    logic [15:0]        r_cell [3];
    logic signed [16:0] r_off  [3];
    hv_pkg::t_status    r_status;
    logic [VW-1:0]      r_vn;
    logic [6:0]         r_slot;
    logic               r_new;

    logic [31:0] hash_val;
    assign hash_val = (32'(r_cell[0]) * 32'(hv_pkg::HASH_MX))
                    ^ (32'(r_cell[1]) * 32'(hv_pkg::HASH_MY))
                    ^ (32'(r_cell[2]) * 32'(hv_pkg::HASH_MZ));

    // hashed table: {used, key, voxel number}
    logic [HMW-1:0] r_hmem [HASH_SLOTS];
    logic [HMW-1:0] r_hrd;
    logic [HW-1:0]  r_idx;
    logic [HW:0]    r_probes;
    logic [HW-1:0]  r_clr;
    logic [VW:0]    r_total;
    logic [47:0]    key;
    assign key = {r_cell[2], r_cell[1], r_cell[0]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_hmem[r_clr] <= '0;
        end else if (i_cmd.alloc) begin
            r_hmem[r_idx] <= {1'b1, key, r_total[VW-1:0]};
        end
        if (i_cmd.probe_rd) r_hrd <= r_hmem[r_idx];
    end

    // per-voxel point counts
    logic [6:0] r_cmem [VOX_CAPACITY];
    logic [6:0] r_crd;
    logic       cap_zero;
    assign cap_zero = (i_cfg.cap == 7'd0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.alloc) begin
            r_cmem[r_total[VW-1:0]] <= cap_zero ? 7'd0 : 7'd1;
        end else if (i_cmd.cnt_upd && (r_crd < i_cfg.cap)) begin
            r_cmem[r_vn] <= r_crd + 7'd1;
        end
        if (i_cmd.cnt_rd) r_crd <= r_cmem[r_vn];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr   <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.clr_start) begin
                r_clr   <= '0;
                r_total <= '0;
            end else if (i_cmd.clr_step) begin
                r_clr <= (r_clr == IDX_LAST) ? '0 : r_clr + 1'b1;
            end else if (i_cmd.alloc) begin
                r_total <= r_total + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_point) begin
            r_int <= i_s_tdata[75:60];
            for (int i = 0; i < 3; i++) begin
                r_rem[i] <= '0;
                r_dvs[i] <= {1'b0, sizes[i]};
            end
            r_dvd[0] <= 32'((pt_x - og_x) & 21'h0FFFFF);
            r_dvd[1] <= 32'((pt_y - og_y) & 21'h0FFFFF);
            r_dvd[2] <= 32'((pt_z - og_z) & 21'h0FFFFF);
            r_neg    <= {d_ax[2][20], d_ax[1][20], d_ax[0][20]};
            r_dcnt   <= '0;
        end else if (i_cmd.div_step) begin
            for (int i = 0; i < 3; i++) begin
                r_dvd[i] <= n_dvd[i];
                r_rem[i] <= n_rem[i];
            end
            r_dcnt <= r_dcnt + 5'd1;
        end

        if (i_cmd.range_latch) begin
            r_status <= (|ax_bad) ? hv_pkg::ST_OOR : hv_pkg::ST_PLACED;
            r_vn     <= '0;
            r_slot   <= '0;
            r_new    <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_cell[i] <= (|ax_bad) ? 16'd0 : r_dvd[i][15:0];
                // remainder r gives 2d - (2c+1)s = 2r - s
                r_off[i]  <= (|ax_bad) ? 17'sd0
                           : signed'(17'({r_rem[i][15:0], 1'b0} - {1'b0, sizes[i]}));
            end
        end

        if (i_cmd.hidx_latch) begin
            r_idx    <= hash_val[HW-1:0];
            r_probes <= '0;
        end else if (i_cmd.probe_next) begin
            r_idx    <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            r_probes <= r_probes + 1'b1;
        end

        if (i_cmd.set_full) r_status <= hv_pkg::ST_TFULL;
        if (i_cmd.alloc) begin
            r_vn     <= r_total[VW-1:0];
            r_new    <= 1'b1;
            r_status <= cap_zero ? hv_pkg::ST_VFULL : hv_pkg::ST_PLACED;
        end
        if (i_cmd.hit_latch) r_vn <= r_hrd[VW-1:0];
        if (i_cmd.cnt_upd) begin
            if (r_crd >= i_cfg.cap) begin
                r_status <= hv_pkg::ST_VFULL;
            end else begin
                r_slot <= r_crd;
            end
        end
    end

    // output register
    logic         r_ovalid;
    logic [1:0]   r_ouser;
    logic [143:0] r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_ouser <= r_status;
            r_odata <= {7'd0, r_int, r_off[2], r_off[1], r_off[0],
                        r_cell[2], r_cell[1], r_cell[0], r_new, r_slot, 14'(r_vn)};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_ouser;
    assign o_m_tdata  = r_odata;

    assign o_stat.action     = i_s_tuser;
    assign o_stat.clr_last   = (r_clr == IDX_LAST);
    assign o_stat.div_last   = (r_dcnt == 5'(hv_pkg::DIV_STEPS - 1));
    assign o_stat.oor        = |ax_bad;
    assign o_stat.used       = r_hrd[HMW-1];
    assign o_stat.hit        = (r_hrd[HMW-2:VW] == key);
    assign o_stat.probe_last = ((r_probes + 1'b1) == PROBE_END);
    assign o_stat.total_full = (r_total >= VOX_END);
    assign o_stat.out_free   = !r_ovalid || i_m_tready;

    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= VOX_END)
        else $error("voxel count past capacity");

    a_alloc_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.alloc |=> r_total == $past(r_total) + 1'b1)
        else $error("allocation did not advance voxel count");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_ovalid || i_m_tready))
        else $error("result overwritten before taken");

endmodule
`default_nettype wire

FILE: hw/rtl/hard_voxelization_unit.sv
// Channel   Dir  Handshake                  Payload
// s_axis    in   i_s_tvalid / o_s_tready    tuser: action; tdata: point, intensity
// m_axis    out  o_m_tvalid / i_m_tready    tuser: status; tdata: voxel result
// cfg       in   i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A point runs a serial shift-subtract division for the cell indices, then a read
// and compare per hash probe, then, when it joins an existing voxel, a read and
// update of its point count. An out-of-range point skips the probes.
// A new-frame item clears the hash table and the voxel count and gives no result.
// After reset the same clearing pass runs before the first item.
// The output register holds a result while the next item is processed; a result
// still waiting when the next one is ready stalls the block. HASH_SLOTS: power of two.
`default_nettype none
module hard_voxelization_unit #(
    parameter int VOX_CAPACITY = 16384,
    parameter int HASH_SLOTS   = 16384
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic         i_s_tuser,   // [0] action
    input  wire logic [79:0]  i_s_tdata,   // x[19:0] y[39:20] z[59:40] intensity[75:60]
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [1:0]        o_m_tuser,   // [1:0] status
    output logic [143:0]      o_m_tdata,   // voxel_number[13:0] slot[20:14] new_voxel[21]
                                           // cell_x/y/z[69:22] offset_x/y/z[120:70]
                                           // intensity_out[136:121]
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [2:0]   i_cfg_index,
    input  wire logic [47:0]  i_cfg_data
);

    hv_pkg::t_cfg r_cfg;
    hv_pkg::t_cmd cmd;
    hv_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x <= hv_pkg::ORIGIN_X_RST;
            r_cfg.origin_y <= hv_pkg::ORIGIN_Y_RST;
            r_cfg.origin_z <= hv_pkg::ORIGIN_Z_RST;
            r_cfg.size_x   <= hv_pkg::SIZE_X_RST;
            r_cfg.size_y   <= hv_pkg::SIZE_Y_RST;
            r_cfg.size_z   <= hv_pkg::SIZE_Z_RST;
            r_cfg.limits   <= hv_pkg::LIMITS_RST;
            r_cfg.cap      <= hv_pkg::CAP_RST;
        end else if (i_cfg_valid) begin
            unique case (hv_pkg::t_cfg_idx'(i_cfg_index))
                hv_pkg::CFG_ORIGIN_X: r_cfg.origin_x <= signed'(i_cfg_data[19:0]);
                hv_pkg::CFG_ORIGIN_Y: r_cfg.origin_y <= signed'(i_cfg_data[19:0]);
                hv_pkg::CFG_ORIGIN_Z: r_cfg.origin_z <= signed'(i_cfg_data[19:0]);
                hv_pkg::CFG_SIZE_X:   r_cfg.size_x   <= i_cfg_data[15:0];
                hv_pkg::CFG_SIZE_Y:   r_cfg.size_y   <= i_cfg_data[15:0];
                hv_pkg::CFG_SIZE_Z:   r_cfg.size_z   <= i_cfg_data[15:0];
                hv_pkg::CFG_LIMITS:   r_cfg.limits   <= i_cfg_data;
                hv_pkg::CFG_CAP:      r_cfg.cap      <= i_cfg_data[6:0];
                default: ;
            endcase
        end
    end

    hv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    hv_dp #(
        .VOX_CAPACITY (VOX_CAPACITY),
        .HASH_SLOTS   (HASH_SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tuser  (i_s_tuser),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tuser  (o_m_tuser),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
`default_nettype wire
